// File: rtl/btn_dbnc_pkg.sv
// shared types and constants for the button debouncer with silence timer
`default_nettype none

package btn_dbnc_pkg;

   localparam int RAW_W    = 5;   // raw pin bits carried per item
   localparam int IDX_W    = 3;   // button index field width
   localparam int THR_W    = 8;   // debounce threshold / mismatch counter width
   localparam int CD_W     = 16;  // silence countdown width
   localparam int CSR_W    = 16;  // widest config register
   localparam int REQ_W    = 8;   // req tdata width
   localparam int RSP_W    = 8;   // rsp tdata width

   localparam logic [THR_W-1:0] THR_RESET    = 8'd5;
   localparam logic [CD_W-1:0]  RELOAD_RESET = 16'd12000;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_READ = 2'd1,
      KIND_INIT = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      CSR_THRESHOLD = 1'b0,
      CSR_RELOAD    = 1'b1
   } csr_index_type;

   // per-lane control for one accepted item
   typedef struct packed {
      logic tick;
      logic init;
      logic clr;
   } lane_ctrl_type;

   // per-lane status toward the merge stage
   typedef struct packed {
      logic latch;      // press latch before this step
      logic latch_nx;   // press latch after this step
      logic level_nx;   // stable level after this step
      logic press;      // released-to-pressed accepted in this step
   } lane_stat_type;

   // accepted item info for the merge stage
   typedef struct packed {
      logic     valid;
      kind_type kind;
   } step_type;

   // result word, first field in the highest bits
   typedef struct packed {
      logic [RAW_W-1:0] stable_levels;
      logic             any_event;
      logic             silence_active;
      logic             press_flag;
   } result_type;

endpackage

`default_nettype wire

// File: rtl/btn_dbnc_lane.sv
// one debounce lane: mismatch counter, stable level and press latch
`default_nettype none

module btn_dbnc_lane
   import btn_dbnc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lane_ctrl_type    ctrl,
   input  wire logic             raw_bit,
   input  wire logic [THR_W-1:0] threshold,
   output lane_stat_type         stat
);

   logic [THR_W-1:0] cnt_ff, cnt_in, cnt_inc;
   logic             level_ff, level_in;
   logic             latch_ff, latch_in;
   logic             press;

   assign cnt_inc = cnt_ff + 1'b1;

   always_comb begin
      cnt_in   = cnt_ff;
      level_in = level_ff;
      latch_in = latch_ff;
      press    = 1'b0;
      if (ctrl.init) begin
         cnt_in   = '0;
         level_in = raw_bit;
         latch_in = 1'b0;
      end else if (ctrl.tick) begin
         if (raw_bit != level_ff) begin
            if (cnt_inc >= threshold) begin
               level_in = raw_bit;
               cnt_in   = '0;
               if (level_ff && !raw_bit) begin
                  press    = 1'b1;
                  latch_in = 1'b1;
               end
            end else begin
               cnt_in = cnt_inc;
            end
         end else begin
            cnt_in = '0;
         end
      end else if (ctrl.clr) begin
         latch_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         level_ff <= 1'b1;
         latch_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         level_ff <= level_in;
         latch_ff <= latch_in;
      end
   end

   assign stat.latch    = latch_ff;
   assign stat.latch_nx = latch_in;
   assign stat.level_nx = level_in;
   assign stat.press    = press;

endmodule

`default_nettype wire

// File: rtl/btn_dbnc_merge.sv
// merge stage: silence countdown, lane summary and two-entry result buffer
`default_nettype none

module btn_dbnc_merge
   import btn_dbnc_pkg::*;
#(
   parameter int BUTTONS        = 5,
   parameter int SILENCE_BUTTON = 0
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire step_type        step,
   input  wire logic [BUTTONS-1:0] rd_sel,
   input  wire lane_stat_type   stat [BUTTONS],
   input  wire logic [CD_W-1:0] silence_reload,
   input  wire logic            out_ready,
   output logic                 out_valid,
   output result_type           out_data,
   output logic                 full
);

   logic [CD_W-1:0] cd_ff, cd_in, cd_base;
   logic            sil_press;
   logic            flag, any;
   logic [RAW_W-1:0] levels;
   result_type      res;

   generate
      if (SILENCE_BUTTON < BUTTONS) begin : g_sil
         assign sil_press = stat[SILENCE_BUTTON].press;
      end else begin : g_nosil
         assign sil_press = 1'b0;
      end
   endgenerate

   always_comb begin
      cd_base = sil_press ? silence_reload : cd_ff;
      cd_in   = cd_ff;
      if (step.valid) begin
         unique case (step.kind)
            KIND_TICK: cd_in = (cd_base != '0) ? cd_base - 1'b1 : cd_base;
            KIND_INIT: cd_in = '0;
            default:   cd_in = cd_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cd_ff <= '0;
      end else begin
         cd_ff <= cd_in;
      end
   end

   always_comb begin
      flag = 1'b0;
      any  = 1'b0;
      for (int i = 0; i < BUTTONS; i++) begin
         flag = flag | (rd_sel[i] & stat[i].latch);
         any  = any | stat[i].latch_nx;
      end
   end

   // levels of missing buttons report released
   generate
      for (genvar b = 0; b < RAW_W; b++) begin : g_lvl
         if (b < BUTTONS) begin : g_have
            assign levels[b] = stat[b].level_nx;
         end else begin : g_none
            assign levels[b] = 1'b1;
         end
      end
   endgenerate

   assign res.press_flag     = flag;
   assign res.silence_active = (cd_in != '0);
   assign res.any_event      = any;
   assign res.stable_levels  = levels;

   // output register plus skid entry
   logic       out_valid_ff, skid_valid_ff;
   result_type out_ff, skid_ff;
   logic       pop;

   assign pop = out_valid_ff & out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (step.valid) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (step.valid) begin
         if (!out_valid_ff || pop) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
   assign full      = skid_valid_ff;

endmodule

`default_nettype wire

// File: rtl/button_debounce_with_silence_timer.sv
// top level of the button debouncer with silence timer
//
// usage:
//  - req channel: one transfer per command; req_tuser carries the kind
//    (tick sample, read-and-clear of one press latch, init), req_tdata the
//    raw pin levels and the button index
//  - every command gives exactly one rsp transfer with the press flag,
//    silence active, any press pending and the debounced levels
//  - one debounce lane per button, all updated in the same cycle; the merge
//    stage runs the silence countdown and summarizes the lanes
//  - each result is registered in the output register, or in the skid entry
//  - throughput: one command per cycle while the skid entry is free
//  - the result sits in an output register backed by one skid entry, so a
//    command is still taken while one result waits; req_tready drops only
//    when both entries are full, and rises again on the next rsp transfer
//  - reset (synchronous): levels released, counters, latches and countdown
//    cleared, threshold 5, silence reload 12000, both result entries empty
//  - csr writes are taken on any cycle with csr_we high and should only be
//    issued while no command is in flight
`default_nettype none

module button_debounce_with_silence_timer
   import btn_dbnc_pkg::*;
#(
   parameter int BUTTONS        = 5,
   parameter int SILENCE_BUTTON = 0
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // req: tdata = raw_levels[4:0], button_index[7:5]; tuser = kind[1:0]
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [REQ_W-1:0] req_tdata,
   input  wire logic [1:0]       req_tuser,
   // rsp: tdata = press_flag[0], silence_active[1], any_event[2],
   //      stable_levels[7:3]
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // config write port
   input  wire logic             csr_we,
   input  wire logic [0:0]       csr_index,
   input  wire logic [CSR_W-1:0] csr_wdata
);

   // config registers
   logic [THR_W-1:0] threshold_ff;
   logic [CD_W-1:0]  reload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THR_RESET;
         reload_ff    <= RELOAD_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_THRESHOLD: threshold_ff <= csr_wdata[THR_W-1:0];
            CSR_RELOAD:    reload_ff    <= csr_wdata[CD_W-1:0];
         endcase
      end
   end

   // request decode
   logic             acc;
   logic             full;
   kind_type         kind;
   logic [RAW_W-1:0] raw;
   logic [IDX_W-1:0] idx;
   step_type         step;

   assign req_tready = !full;
   assign acc        = req_tvalid & req_tready;
   assign kind       = kind_type'(req_tuser);
   assign raw        = req_tdata[RAW_W-1:0];
   assign idx        = req_tdata[RAW_W+IDX_W-1:RAW_W];
   assign step.valid = acc;
   assign step.kind  = kind;

   // debounce lanes
   lane_stat_type       stat [BUTTONS];
   logic [BUTTONS-1:0]  rd_sel;

   generate
      for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
         lane_ctrl_type ctrl;
         logic          raw_bit;

         // buttons without a pin read as released
         if (i < RAW_W) begin : g_pin
            assign raw_bit = raw[i];
         end else begin : g_nopin
            assign raw_bit = 1'b1;
         end

         // index widened by one bit for the compare; the three-bit index still reaches only buttons 0 to 7
         assign rd_sel[i] = acc && (kind == KIND_READ) &&
                            ({1'b0, idx} == (IDX_W+1)'(i));
         assign ctrl.tick = acc && (kind == KIND_TICK);
         assign ctrl.init = acc && (kind == KIND_INIT);
         assign ctrl.clr  = rd_sel[i];

         btn_dbnc_lane u_lane (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .raw_bit   (raw_bit),
            .threshold (threshold_ff),
            .stat      (stat[i])
         );
      end
   endgenerate

   // merge stage and result buffer
   result_type res;

   btn_dbnc_merge #(
      .BUTTONS        (BUTTONS),
      .SILENCE_BUTTON (SILENCE_BUTTON)
   ) u_merge (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .rd_sel         (rd_sel),
      .stat           (stat),
      .silence_reload (reload_ff),
      .out_ready      (rsp_tready),
      .out_valid      (rsp_tvalid),
      .out_data       (res),
      .full           (full)
   );

   assign rsp_tdata = res;

endmodule

`default_nettype wire
